// ===== src/h2r_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h2r_pkg
// Shared constants, stage types and hue ramp helpers for the HSL to RGB core.
// ============================================================================
package h2r_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int HUE_W      = 12;
    localparam int SL_W       = 13;
    localparam int CH_W       = 8;
    localparam int PIPE_DEPTH = 4;

    localparam int FW   = FRAC_BITS + 1;
    localparam int TW   = FRAC_BITS + 2;
    localparam int XW   = (SL_W > FW) ? SL_W : FW;
    localparam int PW   = 2 * FRAC_BITS + 2;
    localparam int VW   = 2 * FRAC_BITS + 1;
    localparam int SW   = 2 * FRAC_BITS + 9;

    localparam logic [FW-1:0]   ONE_F     = FW'(1) << FRAC_BITS;
    localparam logic [XW-1:0]   ONE_X     = XW'(1) << FRAC_BITS;
    localparam logic [TW:0]     ONE_T     = (TW + 1)'(1) << FRAC_BITS;
    localparam logic [TW:0]     THREE_T   = ONE_T * (TW + 1)'(3);
    localparam logic [TW:0]     TWO_T     = ONE_T * (TW + 1)'(2);
    localparam logic [CH_W:0]   CH_MAX    = (CH_W + 1)'((1 << CH_W) - 1);

    typedef struct packed {
        logic [FW-1:0] lum;
        logic [FW-1:0] sat;
        logic [PW-1:0] prod;
        logic          low_lum;
        logic [FW-1:0] k_r;
        logic [FW-1:0] k_g;
        logic [FW-1:0] k_b;
    } front_t;

    typedef struct packed {
        logic [FW-1:0] p;
        logic [FW-1:0] d;
        logic [FW-1:0] k_r;
        logic [FW-1:0] k_g;
        logic [FW-1:0] k_b;
    } mix_t;

    function automatic logic [TW:0] wrap3(input logic [TW:0] x);
        logic [TW:0] r;
        r = (x >= THREE_T) ? (x - THREE_T) : x;
        return r;
    endfunction

    function automatic logic [FW-1:0] ramp_k(input logic [TW:0] t);
        logic [TW+1:0] t2;
        logic [TW+1:0] fall;
        logic [FW-1:0] k;
        t2   = {t, 1'b0};
        fall = {(TWO_T - t), 1'b0};
        if (t2 < {1'b0, ONE_T})
            k = t2[FW-1:0];
        else if (t2 < {1'b0, THREE_T})
            k = ONE_F;
        else if (t < TWO_T)
            k = fall[FW-1:0];
        else
            k = '0;
        return k;
    endfunction

endpackage

// ===== src/h2r_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h2r_front
// Clamp saturation and luminance, form their product and the hue ramp gains.
// ============================================================================
module h2r_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [h2r_pkg::HUE_W-1:0]   hue,
    input  logic [h2r_pkg::SL_W-1:0]    saturation,
    input  logic [h2r_pkg::SL_W-1:0]    luminance,
    output logic                        out_valid,
    output h2r_pkg::front_t             out_data
);
    import h2r_pkg::*;

    logic                 valid_reg;
    front_t               data_reg;
    front_t               data_next;
    logic [FRAC_BITS-1:0] h;
    logic [XW-1:0]        s_x;
    logic [XW-1:0]        l_x;
    logic [FW-1:0]        s_c;
    logic [FW-1:0]        l_c;
    logic [TW:0]          t_g;

    always_comb
    begin
        h   = FRAC_BITS'(hue);
        s_x = XW'(saturation);
        l_x = XW'(luminance);
        s_c = (s_x > ONE_X) ? ONE_F : FW'(s_x);
        l_c = (l_x > ONE_X) ? ONE_F : FW'(l_x);
        t_g = (TW + 1)'(h) * (TW + 1)'(3);

        data_next.lum     = l_c;
        data_next.sat     = s_c;
        data_next.prod    = PW'(l_c) * PW'(s_c);
        data_next.low_lum = ({l_c, 1'b0} < {1'b0, ONE_F});
        data_next.k_r     = ramp_k(wrap3(t_g + ONE_T));
        data_next.k_g     = ramp_k(t_g);
        data_next.k_b     = ramp_k(wrap3(t_g + TWO_T));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/h2r_mix.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h2r_mix
// Form q, p and the ramp span q - p from luminance and saturation.
// ============================================================================
module h2r_mix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  h2r_pkg::front_t in_data,
    output logic            out_valid,
    output h2r_pkg::mix_t   out_data
);
    import h2r_pkg::*;

    logic            valid_reg;
    mix_t            data_reg;
    mix_t            data_next;
    logic [FW+1:0]   ls_hi;
    logic [FW+1:0]   l_w;
    logic [FW+1:0]   s_w;
    logic [FW+1:0]   q_w;
    logic [FW+1:0]   p_w;
    logic [FW+1:0]   d_w;

    always_comb
    begin
        ls_hi = (FW + 2)'(in_data.prod >> FRAC_BITS);
        l_w   = (FW + 2)'(in_data.lum);
        s_w   = (FW + 2)'(in_data.sat);
        if (in_data.low_lum)
            q_w = l_w + ls_hi;
        else
            q_w = l_w + s_w - ls_hi;
        p_w = (l_w << 1) - q_w;
        d_w = q_w - p_w;

        data_next.p   = p_w[FW-1:0];
        data_next.d   = d_w[FW-1:0];
        data_next.k_r = in_data.k_r;
        data_next.k_g = in_data.k_g;
        data_next.k_b = in_data.k_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/h2r_chan.sv =====
`timescale 1ns / 1ps
// ============================================================================
// h2r_chan
// Evaluate one channel ramp and scale it to an 8-bit intensity in two stages.
// ============================================================================
module h2r_chan (
    input  logic                      clk,
    input  logic [h2r_pkg::FW-1:0]    p,
    input  logic [h2r_pkg::FW-1:0]    d,
    input  logic [h2r_pkg::FW-1:0]    k,
    output logic [h2r_pkg::CH_W-1:0]  level
);
    import h2r_pkg::*;

    logic [VW-1:0]   v_reg;
    logic [VW-1:0]   v_next;
    logic [CH_W-1:0] level_reg;
    logic [CH_W-1:0] level_next;
    logic [PW-1:0]   prod;
    logic [PW-1:0]   sum;
    logic [SW-1:0]   scaled;
    logic [CH_W:0]   c;

    always_comb
    begin
        prod   = PW'(d) * PW'(k);
        sum    = (PW'(p) << FRAC_BITS) + prod;
        v_next = sum[VW-1:0];
    end

    always_comb
    begin
        scaled     = (SW'(v_reg) << CH_W) - SW'(v_reg);
        c          = scaled[SW-1:2*FRAC_BITS];
        level_next = (c > CH_MAX) ? CH_MAX[CH_W-1:0] : c[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

// ===== src/hsl_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hsl_to_rgb_converter_core
// Each accepted request passes the front, mix, ramp and level registers to done.
// Throughput: one request per cycle; busy stays low, set by the 4-stage pipe.
// Reset: rst_n clears all valid bits asynchronously; requests in flight drop.
// Results appear for one cycle on done; the receiver cannot stall.
// ============================================================================
module hsl_to_rgb_converter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [h2r_pkg::HUE_W-1:0]   hue,
    input  logic [h2r_pkg::SL_W-1:0]    saturation,
    input  logic [h2r_pkg::SL_W-1:0]    luminance,
    output logic                        done,
    output logic [h2r_pkg::CH_W-1:0]    red,
    output logic [h2r_pkg::CH_W-1:0]    green,
    output logic [h2r_pkg::CH_W-1:0]    blue
);
    import h2r_pkg::*;

    logic   accept;
    logic   front_valid;
    front_t front_data;
    logic   mix_valid;
    mix_t   mix_data;
    logic   v3_reg;
    logic   v4_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    h2r_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .hue        (hue),
        .saturation (saturation),
        .luminance  (luminance),
        .out_valid  (front_valid),
        .out_data   (front_data)
    );

    h2r_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (mix_valid),
        .out_data  (mix_data)
    );

    h2r_chan u_red (
        .clk   (clk),
        .p     (mix_data.p),
        .d     (mix_data.d),
        .k     (mix_data.k_r),
        .level (red)
    );

    h2r_chan u_green (
        .clk   (clk),
        .p     (mix_data.p),
        .d     (mix_data.d),
        .k     (mix_data.k_g),
        .level (green)
    );

    h2r_chan u_blue (
        .clk   (clk),
        .p     (mix_data.p),
        .d     (mix_data.d),
        .k     (mix_data.k_b),
        .level (blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= mix_valid;
            v4_reg <= v3_reg;
        end
    end

    assign done = v4_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_DEPTH done)
        else $error("request did not complete after pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_DEPTH))
        else $error("done without a matching request");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept && saturation == '0, PIPE_DEPTH))
        |-> (red == green && green == blue))
        else $error("zero saturation did not give grey");

endmodule

// ===== verif/hsl_to_rgb_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hsl_to_rgb_checker
// Watches the request and result ports of the HSL to RGB core, predicts the
// red, green and blue levels of each accepted request and compares every
// done strobe, field by field, against the oldest outstanding prediction.
// ============================================================================
module hsl_to_rgb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [h2r_pkg::HUE_W-1:0]   hue,
    input  logic [h2r_pkg::SL_W-1:0]    saturation,
    input  logic [h2r_pkg::SL_W-1:0]    luminance,
    input  logic                        done,
    input  logic [h2r_pkg::CH_W-1:0]    red,
    input  logic [h2r_pkg::CH_W-1:0]    green,
    input  logic [h2r_pkg::CH_W-1:0]    blue,
    output int                          mismatches,
    output int                          outstanding
);

    localparam longint UNIT = longint'(1) << h2r_pkg::FRAC_BITS;

    typedef struct packed {
        logic [h2r_pkg::HUE_W-1:0] hue;
        logic [h2r_pkg::SL_W-1:0]  sat;
        logic [h2r_pkg::SL_W-1:0]  lum;
        logic [h2r_pkg::CH_W-1:0]  red;
        logic [h2r_pkg::CH_W-1:0]  green;
        logic [h2r_pkg::CH_W-1:0]  blue;
    } color_t;

    color_t rgb_pending[$];

    function automatic logic [h2r_pkg::CH_W-1:0] channel_level(
        input longint p,
        input longint q,
        input longint pos
    );
        longint k;
        longint v;
        longint c;
        if (2 * pos < UNIT)
            k = 2 * pos;
        else if (2 * pos < 3 * UNIT)
            k = UNIT;
        else if (pos < 2 * UNIT)
            k = 2 * (2 * UNIT - pos);
        else
            k = 0;
        v = p * UNIT + (q - p) * k;
        if (v < 0)
            v = 0;
        c = (255 * v) / (UNIT * UNIT);
        if (c > 255)
            c = 255;
        return c[h2r_pkg::CH_W-1:0];
    endfunction

    function automatic color_t hsl_to_rgb_color(
        input logic [h2r_pkg::HUE_W-1:0] h_in,
        input logic [h2r_pkg::SL_W-1:0]  s_in,
        input logic [h2r_pkg::SL_W-1:0]  l_in
    );
        longint s;
        longint l;
        longint q;
        longint p;
        longint pos;
        color_t c;
        s = longint'(s_in);
        l = longint'(l_in);
        if (s > UNIT)
            s = UNIT;
        if (l > UNIT)
            l = UNIT;
        if (2 * l < UNIT)
            q = (l * (UNIT + s)) / UNIT;
        else
            q = l + s - (l * s) / UNIT;
        p = 2 * l - q;
        pos = 3 * (longint'(h_in) & (UNIT - 1));
        c.hue   = h_in;
        c.sat   = s_in;
        c.lum   = l_in;
        c.red   = channel_level(p, q, (pos + UNIT) % (3 * UNIT));
        c.green = channel_level(p, q, pos);
        c.blue  = channel_level(p, q, (pos + 2 * UNIT) % (3 * UNIT));
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 20)
            $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        color_t exp_rgb;
        if (rst_n)
        begin
            if (done)
            begin
                if (rgb_pending.size() == 0)
                    report_mismatch($sformatf("result %0d/%0d/%0d with no request outstanding",
                                              red, green, blue));
                else
                begin
                    exp_rgb = rgb_pending.pop_front();
                    if (red !== exp_rgb.red)
                        report_mismatch($sformatf("red h=%0d s=%0d l=%0d: got %0d, exp %0d",
                            exp_rgb.hue, exp_rgb.sat, exp_rgb.lum, red, exp_rgb.red));
                    if (green !== exp_rgb.green)
                        report_mismatch($sformatf("green h=%0d s=%0d l=%0d: got %0d, exp %0d",
                            exp_rgb.hue, exp_rgb.sat, exp_rgb.lum, green, exp_rgb.green));
                    if (blue !== exp_rgb.blue)
                        report_mismatch($sformatf("blue h=%0d s=%0d l=%0d: got %0d, exp %0d",
                            exp_rgb.hue, exp_rgb.sat, exp_rgb.lum, blue, exp_rgb.blue));
                end
            end
            if (start && !busy)
                rgb_pending.push_back(hsl_to_rgb_color(hue, saturation, luminance));
            outstanding = rgb_pending.size();
        end
    end

endmodule

// ===== verif/tb_hsl_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_hsl_to_rgb_converter_core
// Drives directed corner colors and random HSL requests with random idle
// bursts into the converter core; the checker predicts and compares results.
// ============================================================================
module tb_hsl_to_rgb_converter_core;

    localparam int RANDOM_REQUESTS = 800;
    localparam int STEADY_TAIL     = 150;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int FULL            = 1 << h2r_pkg::FRAC_BITS;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [h2r_pkg::HUE_W-1:0]  hue;
    logic [h2r_pkg::SL_W-1:0]   saturation;
    logic [h2r_pkg::SL_W-1:0]   luminance;
    logic                       done;
    logic [h2r_pkg::CH_W-1:0]   red;
    logic [h2r_pkg::CH_W-1:0]   green;
    logic [h2r_pkg::CH_W-1:0]   blue;

    logic                       req_taken;
    int                         mismatches;
    int                         outstanding;
    int                         stall_cycles;

    hsl_to_rgb_converter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .luminance  (luminance),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsl_to_rgb_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .hue         (hue),
        .saturation  (saturation),
        .luminance   (luminance),
        .done        (done),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_taken    <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            req_taken <= start && !busy;
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(
        input int h,
        input int s,
        input int l
    );
        hue        <= h2r_pkg::HUE_W'(h);
        saturation <= h2r_pkg::SL_W'(s);
        luminance  <= h2r_pkg::SL_W'(l);
        start      <= 1'b1;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return FULL;
            2:       return int'($urandom_range(0, 8191));
            3:       return int'($urandom_range(FULL / 2 - 8, FULL / 2 + 8));
            default: return int'($urandom_range(0, FULL));
        endcase
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        hue        = '0;
        saturation = '0;
        luminance  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(0, 0, 0);
        send_request(4095, 4096, 4096);
        send_request(0, 4096, 2048);
        send_request(0, 4096, 2047);
        send_request(682, 4096, 2048);
        send_request(683, 4096, 2048);
        send_request(1365, 4096, 2048);
        send_request(1366, 4096, 2048);
        idle_burst();
        send_request(2048, 4096, 2048);
        send_request(2730, 4096, 2048);
        send_request(2731, 4096, 2048);
        send_request(3413, 4096, 1000);
        send_request(3414, 3000, 3500);
        send_request(1234, 0, 3000);
        send_request(4000, 0, 4096);
        send_request(100, 8191, 8191);
        idle_burst();
        send_request(1000, 4097, 3000);
        send_request(2000, 3000, 4097);
        send_request(3000, 6000, 1);
        send_request(2500, 1, 4095);
        send_request(1, 4096, 1);
        send_request(2047, 2048, 4095);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n < RANDOM_REQUESTS - STEADY_TAIL && $urandom_range(0, 5) == 0)
                idle_burst();
            send_request(int'($urandom_range(0, 4095)), pick_level(), pick_level());
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (2 * h2r_pkg::PIPE_DEPTH) @(negedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
